// ===== rtl/leb_pkg.sv =====
package leb_pkg;

	// storage defaults
	localparam int MAX_LEN_DEF   = 16;
	localparam logic [4:0] LIMIT_RESET = 5'd16;

	// fixed field widths
	localparam int KEY_W   = 8;
	localparam int CHAR_W  = 7;
	localparam int KIND_W  = 2;
	localparam int POS_W   = 5;
	localparam int LIMIT_W = 5;

	// key codes
	localparam logic [KEY_W-1:0] KEY_PRINT_LO = 8'd33;
	localparam logic [KEY_W-1:0] KEY_PRINT_HI = 8'd127;
	localparam logic [KEY_W-1:0] KEY_EXT      = 8'd224;
	localparam logic [KEY_W-1:0] KEY_LEFT     = 8'd75;
	localparam logic [KEY_W-1:0] KEY_RIGHT    = 8'd77;
	localparam logic [KEY_W-1:0] KEY_HOME     = 8'd71;
	localparam logic [KEY_W-1:0] KEY_END      = 8'd79;
	localparam logic [KEY_W-1:0] KEY_DEL      = 8'd83;
	localparam logic [KEY_W-1:0] KEY_BKSP     = 8'd8;
	localparam logic [KEY_W-1:0] KEY_ENTER    = 8'd13;
	localparam logic [KEY_W-1:0] KEY_ESC      = 8'd27;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
	localparam logic [KIND_W-1:0] KIND_TEXT   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_CANCEL = 2'd3;

endpackage

// ===== rtl/line_edit_buffer.sv =====
// channel  | dir | handshake            | payload
// key in   | in  | in_valid / in_stall  | key_byte
// result   | out | out_valid / out_stall| kind, text_char, cursor, length, last
// limit    | in  | line_limit_we        | line_limit
//
// a status-only key is decoded, then loaded into the output register
// insert and delete shift the line through the ram, one character a cycle;
// an insert runs decode, shift, put of the new character and output load;
// a delete or backspace runs decode, shift and output load
// enter streams the line one character at a time, each by a ram read and an output load
// stalls on the result side hold the sequencer in its load state; one finished
// item may wait in the output register while the next key is taken
// arst_n clears cursor, length, the extended-key flag and sets the limit to 16
module line_edit_buffer
	import leb_pkg::*;
#(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [KEY_W-1:0]   key_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [KIND_W-1:0]  kind,
	output logic [CHAR_W-1:0]  text_char,
	output logic [POS_W-1:0]   cursor,
	output logic [POS_W-1:0]   length,
	output logic               last,
	input  logic               line_limit_we,
	input  logic [LIMIT_W-1:0] line_limit
);

	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CW = $clog2(MAX_LEN + 1);
	localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SHIFT  = 3'd1;
	localparam logic [2:0] ST_PUT    = 3'd2;
	localparam logic [2:0] ST_EMIT   = 3'd3;
	localparam logic [2:0] ST_ENT_RD = 3'd4;
	localparam logic [2:0] ST_ENT_LD = 3'd5;

	logic [2:0]         state_q;
	logic [CHAR_W-1:0]  key_q;
	logic               ext_q;
	logic [CW-1:0]      cur_q;
	logic [CW-1:0]      len_q;
	logic [LIMIT_W-1:0] line_limit_q;
	logic [KIND_W-1:0]  res_kind_q;
	logic               ins_q;
	logic [AW-1:0]      rd_idx_q;
	logic [CW-1:0]      rd_left_q;
	logic               wr_pend_q;
	logic [AW-1:0]      wr_addr_q;
	logic               out_valid_q;

	logic               accept;
	logic               slot_free;
	logic               is_last;
	logic               can_insert;
	logic               is_print;
	logic [LW-1:0]      lim_w;
	logic [2:0]         dec_state;
	logic [KIND_W-1:0]  dec_kind;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [CHAR_W-1:0]  mem_wdata;
	logic [CHAR_W-1:0]  mem_rdata;
	logic               out_load;
	logic [KIND_W-1:0]  ld_kind;
	logic [CHAR_W-1:0]  ld_text;
	logic               ld_last;

	// handshake
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	// limit in use and room check
	assign lim_w = (LW'(line_limit_q) > LW'(MAX_LEN)) ? LW'(MAX_LEN) : LW'(line_limit_q);
	assign can_insert = LW'(len_q) < lim_w;
	assign is_last    = (CW'(rd_idx_q) + CW'(1)) == len_q;
	assign is_print   = (key_byte >= KEY_PRINT_LO) && (key_byte <= KEY_PRINT_HI);

	// line storage
	leb_ram #(
		.WIDTH (CHAR_W),
		.DEPTH (MAX_LEN),
		.AW    (AW)
	) u_line_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (rd_idx_q),
		.rdata (mem_rdata)
	);

	// ram write port: shift moves or new character
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = wr_addr_q;
		mem_wdata = mem_rdata;
		unique case (state_q)
			ST_SHIFT: begin
				mem_we = wr_pend_q;
			end
			ST_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = AW'(cur_q);
				mem_wdata = key_q;
			end
			default: begin
			end
		endcase
	end

	// output register load
	always_comb begin
		out_load = 1'b0;
		ld_kind  = res_kind_q;
		ld_text  = '0;
		ld_last  = 1'b1;
		unique case (state_q)
			ST_EMIT: begin
				out_load = slot_free;
			end
			ST_ENT_LD: begin
				out_load = slot_free;
				ld_kind  = KIND_TEXT;
				ld_text  = mem_rdata;
				ld_last  = is_last;
			end
			default: begin
			end
		endcase
	end

	// next state and result kind for an incoming key
	always_comb begin
		dec_state = ST_EMIT;
		dec_kind  = KIND_STATUS;
		if (ext_q) begin
			if (key_byte == KEY_DEL && cur_q < len_q) begin
				dec_state = ST_SHIFT;
			end
		end else if (is_print) begin
			if (can_insert) begin
				dec_state = ST_SHIFT;
			end
		end else if (key_byte == KEY_BKSP) begin
			if (cur_q != '0) begin
				dec_state = ST_SHIFT;
			end
		end else if (key_byte == KEY_ENTER) begin
			if (len_q == '0) begin
				dec_kind = KIND_EMPTY;
			end else begin
				dec_state = ST_ENT_RD;
			end
		end else if (key_byte == KEY_ESC) begin
			dec_kind = KIND_CANCEL;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			kind      <= ld_kind;
			text_char <= ld_text;
			cursor    <= POS_W'(cur_q);
			length    <= POS_W'(len_q);
			last      <= ld_last;
		end
	end

	// limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_limit_q <= LIMIT_RESET;
		end else if (line_limit_we) begin
			line_limit_q <= line_limit;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			key_q       <= '0;
			ext_q       <= 1'b0;
			cur_q       <= '0;
			len_q       <= '0;
			res_kind_q  <= KIND_STATUS;
			ins_q       <= 1'b0;
			rd_idx_q    <= '0;
			rd_left_q   <= '0;
			wr_pend_q   <= 1'b0;
			wr_addr_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				// decode one key
				ST_IDLE: begin
					if (accept) begin
						res_kind_q <= dec_kind;
						key_q      <= key_byte[CHAR_W-1:0];
						wr_pend_q  <= 1'b0;
						state_q    <= dec_state;
						if (ext_q) begin
							ext_q <= 1'b0;
							unique case (key_byte)
								KEY_LEFT: begin
									if (cur_q != '0) cur_q <= cur_q - CW'(1);
								end
								KEY_RIGHT: begin
									if (cur_q < len_q) cur_q <= cur_q + CW'(1);
								end
								KEY_HOME: begin
									cur_q <= '0;
								end
								KEY_END: begin
									cur_q <= len_q;
								end
								KEY_DEL: begin
									if (cur_q < len_q) begin
										ins_q     <= 1'b0;
										rd_idx_q  <= AW'(cur_q + CW'(1));
										rd_left_q <= len_q - cur_q - CW'(1);
									end
								end
								default: begin
								end
							endcase
						end else if (is_print) begin
							if (can_insert) begin
								ins_q     <= 1'b1;
								rd_idx_q  <= AW'(len_q - CW'(1));
								rd_left_q <= len_q - cur_q;
							end
						end else if (key_byte == KEY_EXT) begin
							ext_q <= 1'b1;
						end else if (key_byte == KEY_BKSP) begin
							if (cur_q != '0) begin
								ins_q     <= 1'b0;
								cur_q     <= cur_q - CW'(1);
								rd_idx_q  <= AW'(cur_q);
								rd_left_q <= len_q - cur_q;
							end
						end else if (key_byte == KEY_ENTER) begin
							if (len_q != '0) begin
								rd_idx_q <= '0;
							end
						end
					end
				end

				// move characters one place, read and write overlapped
				ST_SHIFT: begin
					if (rd_left_q != '0) begin
						wr_pend_q <= 1'b1;
						wr_addr_q <= ins_q ? (rd_idx_q + AW'(1)) : (rd_idx_q - AW'(1));
						rd_idx_q  <= ins_q ? (rd_idx_q - AW'(1)) : (rd_idx_q + AW'(1));
						rd_left_q <= rd_left_q - CW'(1);
					end else begin
						wr_pend_q <= 1'b0;
						if (!wr_pend_q) begin
							if (ins_q) begin
								state_q <= ST_PUT;
							end else begin
								len_q   <= len_q - CW'(1);
								state_q <= ST_EMIT;
							end
						end
					end
				end

				// new character at the cursor
				ST_PUT: begin
					cur_q   <= cur_q + CW'(1);
					len_q   <= len_q + CW'(1);
					state_q <= ST_EMIT;
				end

				// single result, then clear after enter or esc
				ST_EMIT: begin
					if (out_load) begin
						if (res_kind_q == KIND_EMPTY || res_kind_q == KIND_CANCEL) begin
							cur_q <= '0;
							len_q <= '0;
						end
						state_q <= ST_IDLE;
					end
				end

				// stream the line out
				ST_ENT_RD: begin
					state_q <= ST_ENT_LD;
				end

				ST_ENT_LD: begin
					if (out_load) begin
						if (is_last) begin
							cur_q   <= '0;
							len_q   <= '0;
							state_q <= ST_IDLE;
						end else begin
							rd_idx_q <= rd_idx_q + AW'(1);
							state_q  <= ST_ENT_RD;
						end
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// cursor never passes the end of the line
	a_cur_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q <= len_q)
		else $error("cursor beyond line length");

	// line never longer than the store
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(len_q) <= CW'(MAX_LEN))
		else $error("line length beyond store depth");

	// enter on an empty line and esc leave an empty line
	a_clear_after: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && out_load &&
		 (res_kind_q == KIND_EMPTY || res_kind_q == KIND_CANCEL))
		|=> (len_q == '0 && cur_q == '0 && state_q == ST_IDLE))
		else $error("line not cleared after enter or esc");

	// store written only while an item is at work
	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q != ST_IDLE))
		else $error("store written while idle");

	// an accepted item keeps the block busy in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("block not busy after taking an item");

endmodule

// ===== rtl/leb_ram.sv =====
module leb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// single write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== tb/sv/line_edit_buffer_tb.sv =====
module line_edit_buffer_tb;
	import leb_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINE_MAX    = MAX_LEN_DEF;
	localparam int SETTLE      = 40;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_LEN    = 400;
	localparam int PHASE_KEYS  = 30;
	localparam int DIR_N       = 26;
	localparam int MODE_TX     = 0;
	localparam int MODE_RX     = 1;
	localparam int MODE_NONE   = 2;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [CHAR_W-1:0] ch;
		logic [POS_W-1:0]  cur;
		logic [POS_W-1:0]  len;
		logic              last;
	} line_result_t;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic              typed;
		logic [KIND_W-1:0] kind;
		logic [POS_W-1:0]  cur;
		logic [POS_W-1:0]  len;
	} key_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [KEY_W-1:0]   key_byte = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [KIND_W-1:0]  kind;
	logic [CHAR_W-1:0]  text_char;
	logic [POS_W-1:0]   cursor;
	logic [POS_W-1:0]   length;
	logic               last;
	logic               line_limit_we = 1'b0;
	logic [LIMIT_W-1:0] line_limit = '0;

	// predicted editor state
	logic [CHAR_W-1:0]  ed_line [LINE_MAX];
	int                 ed_cur;
	int                 ed_len;
	bit                 ed_ext;
	logic [LIMIT_W-1:0] ed_limit;

	line_result_t results_q [$];
	line_result_t step_out [$];

	int tx_idle;
	int rx_idle;
	int hold_req;
	int hold_left;
	int cycles;
	int errors;
	int results_seen;
	int edit_keys;
	int stray_keys;
	int limits_used;

	// keys with the status they must leave behind where it is obvious
	key_row_t dir_rows [DIR_N] = '{
		'{KEY_BKSP,     1'b1, KIND_STATUS, 5'd0, 5'd0},
		'{KEY_ENTER,    1'b1, KIND_EMPTY,  5'd0, 5'd0},
		'{8'd0,         1'b1, KIND_STATUS, 5'd0, 5'd0},
		'{8'd255,       1'b1, KIND_STATUS, 5'd0, 5'd0},
		'{8'd32,        1'b1, KIND_STATUS, 5'd0, 5'd0},
		'{KEY_PRINT_LO, 1'b1, KIND_STATUS, 5'd1, 5'd1},
		'{KEY_PRINT_HI, 1'b1, KIND_STATUS, 5'd2, 5'd2},
		'{KEY_EXT,      1'b1, KIND_STATUS, 5'd2, 5'd2},
		'{KEY_LEFT,     1'b1, KIND_STATUS, 5'd1, 5'd2},
		'{8'd65,        1'b0, KIND_STATUS, 5'd0, 5'd0},
		'{KEY_EXT,      1'b1, KIND_STATUS, 5'd2, 5'd3},
		'{KEY_HOME,     1'b1, KIND_STATUS, 5'd0, 5'd3},
		'{KEY_EXT,      1'b1, KIND_STATUS, 5'd0, 5'd3},
		'{KEY_LEFT,     1'b1, KIND_STATUS, 5'd0, 5'd3},
		'{KEY_EXT,      1'b1, KIND_STATUS, 5'd0, 5'd3},
		'{KEY_DEL,      1'b1, KIND_STATUS, 5'd0, 5'd2},
		'{KEY_EXT,      1'b1, KIND_STATUS, 5'd0, 5'd2},
		'{KEY_END,      1'b1, KIND_STATUS, 5'd2, 5'd2},
		'{KEY_EXT,      1'b1, KIND_STATUS, 5'd2, 5'd2},
		'{KEY_RIGHT,    1'b1, KIND_STATUS, 5'd2, 5'd2},
		'{KEY_EXT,      1'b1, KIND_STATUS, 5'd2, 5'd2},
		'{KEY_DEL,      1'b1, KIND_STATUS, 5'd2, 5'd2},
		'{KEY_EXT,      1'b1, KIND_STATUS, 5'd2, 5'd2},
		'{KEY_ENTER,    1'b1, KIND_STATUS, 5'd2, 5'd2},
		'{KEY_ENTER,    1'b0, KIND_STATUS, 5'd0, 5'd0},
		'{KEY_ESC,      1'b1, KIND_CANCEL, 5'd0, 5'd0}
	};

	line_edit_buffer u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.key_byte      (key_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind),
		.text_char     (text_char),
		.cursor        (cursor),
		.length        (length),
		.last          (last),
		.line_limit_we (line_limit_we),
		.line_limit    (line_limit)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("line_edit_buffer_tb: timeout after %0d cycles", cycles);
			$display("line_edit_buffer_tb: FAIL");
			$finish;
		end
	end

	function automatic int usable_limit();
		return (ed_limit > LINE_MAX) ? LINE_MAX : int'(ed_limit);
	endfunction

	function automatic line_result_t make_result(logic [KIND_W-1:0] k, logic [CHAR_W-1:0] c,
			int cur, int len, logic lst);
		line_result_t r;
		r.kind = k;
		r.ch   = c;
		r.cur  = cur[POS_W-1:0];
		r.len  = len[POS_W-1:0];
		r.last = lst;
		return r;
	endfunction

	task automatic clear_editor();
		ed_cur = 0;
		ed_len = 0;
		ed_ext = 1'b0;
	endtask

	// close the gap left by the character at pos
	task automatic remove_char(input int pos);
		for (int i = pos; i + 1 < ed_len && i + 1 < LINE_MAX; i++)
			ed_line[i] = ed_line[i + 1];
		ed_len--;
	endtask

	// work out the results one key causes and move the editor state on
	task automatic edit_line(input logic [KEY_W-1:0] b);
		step_out.delete();
		if (ed_ext) begin
			ed_ext = 1'b0;
			if (b == KEY_LEFT) begin
				if (ed_cur > 0) ed_cur--;
			end else if (b == KEY_RIGHT) begin
				if (ed_cur < ed_len) ed_cur++;
			end else if (b == KEY_HOME) begin
				ed_cur = 0;
			end else if (b == KEY_END) begin
				ed_cur = ed_len;
			end else if (b == KEY_DEL) begin
				if (ed_cur < ed_len) remove_char(ed_cur);
			end
		end else if (b >= KEY_PRINT_LO && b <= KEY_PRINT_HI) begin
			if (ed_len < usable_limit()) begin
				for (int i = ed_len; i > ed_cur; i--)
					ed_line[i] = ed_line[i - 1];
				ed_line[ed_cur] = b[CHAR_W-1:0];
				ed_len++;
				ed_cur++;
			end
		end else if (b == KEY_EXT) begin
			ed_ext = 1'b1;
		end else if (b == KEY_BKSP) begin
			if (ed_cur > 0) begin
				remove_char(ed_cur - 1);
				ed_cur--;
			end
		end else if (b == KEY_ENTER) begin
			if (ed_len == 0)
				step_out.push_back(make_result(KIND_EMPTY, '0, ed_cur, 0, 1'b1));
			else
				for (int i = 0; i < ed_len; i++)
					step_out.push_back(make_result(KIND_TEXT, ed_line[i], ed_cur, ed_len,
						i + 1 == ed_len));
			clear_editor();
			return;
		end else if (b == KEY_ESC) begin
			step_out.push_back(make_result(KIND_CANCEL, '0, ed_cur, ed_len, 1'b1));
			clear_editor();
			return;
		end
		step_out.push_back(make_result(KIND_STATUS, '0, ed_cur, ed_len, 1'b1));
	endtask

	task automatic report_fail(input string what, input line_result_t want,
			input line_result_t got);
		errors++;
		if (errors <= 10)
			$display("%0t %s: want kind %0d char %0d cur %0d len %0d last %0d,%s%0d%s%0d%s%0d%s%0d%s%0d",
				$realtime, what, want.kind, want.ch, want.cur, want.len, want.last,
				" got kind ", got.kind, " char ", got.ch, " cur ", got.cur,
				" len ", got.len, " last ", got.last);
	endtask

	// offer one key, wait for it to be taken, then log what it should produce
	task automatic send_key(input logic [KEY_W-1:0] b, input bit typed,
			input line_result_t typed_res);
		while ($urandom_range(0, 99) < tx_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		key_byte <= b;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		edit_line(b);
		if (typed)
			results_q.push_back(typed_res);
		else
			foreach (step_out[i])
				results_q.push_back(step_out[i]);
	endtask

	task automatic send_plain(input logic [KEY_W-1:0] b);
		send_key(b, 1'b0, '0);
	endtask

	// let every expected result out and the sequencer settle
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (results_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_limit(input logic [LIMIT_W-1:0] v);
		line_limit_we <= 1'b1;
		line_limit    <= v;
		@(posedge clk);
		line_limit_we <= 1'b0;
		ed_limit = v;
		limits_used++;
	endtask

	task automatic set_idling(input int mode);
		case (mode)
			MODE_TX: begin
				tx_idle = 31;
				rx_idle = 87;
			end
			MODE_RX: begin
				tx_idle = 87;
				rx_idle = 31;
			end
			default: begin
				tx_idle = 0;
				rx_idle = 0;
			end
		endcase
	endtask

	function automatic logic [KEY_W-1:0] pick_ext_code();
		case ($urandom_range(0, 5))
			0: return KEY_LEFT;
			1: return KEY_RIGHT;
			2: return KEY_HOME;
			3: return KEY_END;
			4: return KEY_DEL;
			default: return KEY_W'($urandom_range(0, 255));
		endcase
	endfunction

	// one editing gesture: mostly well-formed sequences, some stray bytes
	task automatic send_gesture();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			send_plain(KEY_W'($urandom_range(33, 127)));
			edit_keys++;
		end else if (r < 60) begin
			send_plain(KEY_EXT);
			send_plain(pick_ext_code());
			edit_keys += 2;
		end else if (r < 68) begin
			send_plain(KEY_BKSP);
			edit_keys++;
		end else if (r < 75) begin
			send_plain(KEY_ENTER);
			edit_keys++;
		end else if (r < 78) begin
			send_plain(KEY_ESC);
			edit_keys++;
		end else if (r < 88) begin
			send_plain(KEY_W'($urandom_range(0, 255)));
			stray_keys++;
		end else begin
			// fill the line past its limit, then in half the cases submit it
			repeat (usable_limit() + 2)
				send_plain(KEY_W'($urandom_range(33, 127)));
			edit_keys += usable_limit() + 2;
			if ($urandom_range(0, 1)) begin
				send_plain(KEY_ENTER);
				edit_keys++;
			end
		end
	endtask

	// result side: random stall, or a long hold-off on request
	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < rx_idle);
		end
	end

	// compare each result taken with the oldest one still owed
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (results_q.size() == 0)
				report_fail("result with none expected", '0,
					make_result(kind, text_char, cursor, length, last));
			else if (results_q[0] != make_result(kind, text_char, cursor, length, last))
				report_fail("result mismatch", results_q[0],
					make_result(kind, text_char, cursor, length, last));
			if (results_q.size() != 0)
				void'(results_q.pop_front());
		end
	end

	// stimulus
	initial begin
		logic [LIMIT_W-1:0] limits [7];
		line_result_t row_res;

		limits = '{5'd0, 5'd1, 5'd31, 5'd0, 5'd16, 5'd0, 5'd16};
		limits[3] = LIMIT_W'($urandom_range(2, 15));
		limits[5] = LIMIT_W'($urandom_range(2, 15));
		clear_editor();
		ed_limit = LIMIT_RESET;
		tx_idle = 0;
		rx_idle = 0;
		hold_req = 0;
		hold_left = 0;
		cycles = 0;
		errors = 0;
		results_seen = 0;
		edit_keys = 0;
		stray_keys = 0;
		limits_used = 1;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed keys at the reset limit
		set_idling(MODE_TX);
		for (int i = 0; i < DIR_N; i++) begin
			row_res = make_result(dir_rows[i].kind, '0, int'(dir_rows[i].cur),
				int'(dir_rows[i].len), 1'b1);
			send_key(dir_rows[i].key, dir_rows[i].typed, row_res);
		end
		edit_keys += DIR_N;

		// random phases, each under its own limit
		for (int p = 0; p < 7; p++) begin
			int goal;
			wait_drained();
			write_limit(limits[p]);
			set_idling(p < 3 ? MODE_TX : (p < 5 ? MODE_RX : MODE_NONE));
			if (p == 4) begin
				// block the result side while the keys keep coming
				hold_req = HOLD_LEN;
				repeat (LINE_MAX + 6)
					send_plain(KEY_W'($urandom_range(33, 127)));
				send_plain(KEY_ENTER);
				edit_keys += LINE_MAX + 7;
			end
			goal = edit_keys + PHASE_KEYS;
			while (edit_keys < goal)
				send_gesture();
		end

		wait_drained();
		errors += results_q.size();
		$display("line_edit_buffer_tb: %0d edit keys and %0d stray bytes sent, %0d results checked",
			edit_keys, stray_keys, results_seen);
		$display("line_edit_buffer_tb: %0d line limits used, sender and receiver idling in turn",
			limits_used);
		if (errors == 0)
			$display("line_edit_buffer_tb: PASS");
		else
			$display("line_edit_buffer_tb: FAIL");
		$finish;
	end

endmodule

// ===== line_edit_buffer.f =====
rtl/leb_pkg.sv
rtl/leb_ram.sv
rtl/line_edit_buffer.sv
tb/sv/line_edit_buffer_tb.sv
